// File: src/r1tcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r1tcf_pkg
// Shared types, language codes and the Polish remap table of the decoder.
// ----------------------------------------------------------------------------
package r1tcf_pkg;

  // Language repair modes held in the encoding register
  localparam logic [1:0] ENC_RUSSIAN = 2'd0;
  localparam logic [1:0] ENC_ENGLISH = 2'd1;
  localparam logic [1:0] ENC_POLISH  = 2'd2;
  localparam logic [1:0] ENC_OTHER   = 2'd3;
  localparam logic [1:0] ENC_RESET   = ENC_OTHER;

  // Units up to this value pass the rotate undo unchanged
  localparam logic [15:0] ROT_LIMIT = 16'd33;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_in_record;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic        end_of_string;
  } out_item_t;

  // Polish code point repair; unmatched points pass through
  function automatic logic [15:0] polish_map(input logic [15:0] c);
    logic [15:0] r;
    begin
      case (c)
        16'd143: r = 16'h0179;
        16'd163: r = 16'h0141;
        16'd165: r = 16'h0104;
        16'd175: r = 16'h017B;
        16'd179: r = 16'h0142;
        16'd182: r = 16'd179;    // centering format code
        16'd185: r = 16'h0105;
        16'd191: r = 16'h017C;
        16'd198: r = 16'h0106;
        16'd202: r = 16'h0118;
        16'd209: r = 16'h0143;
        16'd230: r = 16'h0107;
        16'd234: r = 16'h0119;
        16'd241: r = 16'h0144;
        16'd338: r = 16'h015A;
        16'd339: r = 16'h015B;
        16'd376: r = 16'h017A;
        default: r = c;
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/r1tcf_repair.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r1tcf_repair
// Undoes the rotate-by-one and applies the language and Cyrillic repairs.
// ----------------------------------------------------------------------------
module r1tcf_repair (
  input  logic [1:0]  enc,
  input  logic [15:0] unit_in,
  output logic [15:0] char_out
);
  import r1tcf_pkg::*;

  logic [15:0] rot;
  logic [15:0] lang;

  // Step every unit above the limit down by one
  assign rot = (unit_in > ROT_LIMIT) ? unit_in - 16'd1 : unit_in;

  // Apply the language repair
  always_comb begin
    lang = rot;
    case (enc)
      ENC_RUSSIAN: begin
        if (rot inside {[16'h00C0:16'h00FF]}) lang = rot + 16'h0350;
      end
      ENC_ENGLISH: begin
        case (rot)
          16'd128: lang = 16'h00C7;
          16'd130: lang = 16'h00E9;
          16'd135: lang = 16'h00E7;
          default: lang = rot;
        endcase
      end
      ENC_POLISH: lang = polish_map(rot);
      default:    lang = rot;
    endcase
  end

  // Fold scrambled Cyrillic back, in every mode but Russian
  always_comb begin
    char_out = lang;
    if (enc != ENC_RUSSIAN) begin
      if (lang inside {[16'h044D:16'h0452]}) begin
        char_out = lang - 16'h044D + 16'h0410;
      end else if (lang == 16'h0453) begin
        char_out = 16'h0401;
      end else if (lang inside {[16'h0454:16'h0467]}) begin
        char_out = lang - 16'h0454 + 16'h0416;
      end else if (lang inside {[16'h0468:16'h046C]}) begin
        char_out = lang - 16'h0468 + 16'h042B;
      end
    end
  end

endmodule

// File: src/rot1_text_charset_fixup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rot1_text_charset_fixup
// Text record decoder: rotate-by-one undo, language repair, string cut-off.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_item) carries one 16-bit code
//   unit per item plus a flag marking the final slot of a record. The result
//   channel (out_valid/out_ready/out_item) gives one decoded character per
//   unit, or a terminator (char 0, end_of_string 1) on a zero unit or on the
//   final slot. Units after a terminator give no result up to and including
//   the final slot of the record, after which the next record starts open.
//   cfg_we/cfg_wdata write the language mode; write it only while idle.
//   An accepted item passes the input register, then the result register.
//   The block takes one item per cycle while the receiver does not stall,
//   set by the combinational repair logic between the two registers.
//   When the receiver stalls, the result register holds and in_ready drops
//   once the input register is also full; no item is lost.
//   Reset clears both valid flags, opens the string and sets the mode to
//   "other" (fold Cyrillic only).
// ----------------------------------------------------------------------------
module rot1_text_charset_fixup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  r1tcf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output r1tcf_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata
);
  import r1tcf_pkg::*;

  logic [1:0]  enc_r;
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        fin_r;
  logic        fin_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;
  logic        s1_adv;
  logic        is_term;
  logic        emit;
  logic [15:0] rep_char;

  // Advance the input register when the result register is free
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign is_term = s1_item_r.last_in_record || (s1_item_r.code_unit == 16'd0);
  assign emit    = !fin_r;

  r1tcf_repair u_repair (
    .enc      (enc_r),
    .unit_in  (s1_item_r.code_unit),
    .char_out (rep_char)
  );

  // Hold the language mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r <= ENC_RESET;
    end else if (cfg_we) begin
      enc_r <= cfg_wdata;
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // Track the string state and form the next result
  always_comb begin
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    if (s1_adv) begin
      if (fin_r) begin
        if (s1_item_r.last_in_record) fin_nxt = 1'b0;
      end else if (is_term) begin
        fin_nxt = !s1_item_r.last_in_record;
      end
      if (emit) begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.end_of_string = is_term;
        out_item_nxt.out_char      = is_term ? 16'd0 : rep_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A terminator always carries a zero character
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.end_of_string |-> out_item_r.out_char == 16'd0)
    else $error("terminator with non-zero character");

  // The final slot of a record always reopens the string
  a_last_opens: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_item_r.last_in_record |=> !fin_r)
    else $error("string still finished after record end");

  // A dropped item leaves the result register empty
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && fin_r |=> !out_valid_r)
    else $error("result appeared for a dropped item");

  // A non-final zero unit closes the string
  a_zero_closes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !fin_r && !s1_item_r.last_in_record && s1_item_r.code_unit == 16'd0
    |=> fin_r && out_valid_r && out_item_r.end_of_string)
    else $error("zero unit did not end the string");

endmodule
